FILE: src/wtcr_pkg.sv
package wtcr_pkg;

    localparam int RES_W  = 24;                  // resistance and register width
    localparam int MAG_W  = 15;                  // weight magnitude
    localparam int WGT_W  = 16;                  // signed weight
    localparam int NUM_W  = 2 * RES_W + MAG_W;   // on * off * largest magnitude
    localparam int DEN_W  = RES_W + MAG_W + 1;   // on * M + (off - on) * |w|
    localparam int NCNT_W = 9;
    localparam int OCNT_W = 5;

    typedef logic [1:0]         t_func;
    typedef logic [1:0]         t_status;
    typedef logic [1:0]         t_cfg_index;
    typedef logic [RES_W-1:0]   t_res;
    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic signed [WGT_W-1:0] t_weight;

    localparam t_func FN_CLEAR = 2'd0;
    localparam t_func FN_WRITE = 2'd1;
    localparam t_func FN_READ  = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_ZERO      = 2'd1;
    localparam t_status ST_RANGE_BAD = 2'd2;
    localparam t_status ST_INDEX     = 2'd3;

    localparam t_cfg_index CFG_ON_RES  = 2'd0;
    localparam t_cfg_index CFG_OFF_RES = 2'd1;
    localparam t_cfg_index CFG_NEURONS = 2'd2;
    localparam t_cfg_index CFG_OUTPUTS = 2'd3;

    localparam t_res             RON_RESET  = 24'd1000;
    localparam t_res             ROFF_RESET = 24'd1000000;
    localparam logic [NCNT_W-1:0] NCNT_RESET = 9'd256;
    localparam logic [OCNT_W-1:0] OCNT_RESET = 5'd16;

    // operands of one resistance calculation
    typedef struct packed {
        t_res ron;
        t_res roff;
        t_mag m;
        t_mag mag;
    } t_calc_op;

endpackage

FILE: src/wtcr_ifs.sv
interface wtcr_in_if;
    logic                valid;
    logic                ready;
    wtcr_pkg::t_func     func;
    logic [7:0]          neuron;
    logic [3:0]          output_req;
    logic                side;
    wtcr_pkg::t_weight   weight;

    modport source (output valid, func, neuron, output_req, side, weight, input ready);
    modport sink   (input valid, func, neuron, output_req, side, weight, output ready);
endinterface

interface wtcr_out_if;
    logic                valid;
    logic                ready;
    wtcr_pkg::t_res      resistance;
    wtcr_pkg::t_status   status;

    modport source (output valid, resistance, status, input ready);
    modport sink   (input valid, resistance, status, output ready);
endinterface

interface wtcr_cfg_if;
    logic                 valid;
    logic                 ready;
    wtcr_pkg::t_cfg_index index;
    wtcr_pkg::t_res       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/wtcr_calc.sv
module wtcr_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  wtcr_pkg::t_calc_op i_op,
    output logic               o_done,
    output wtcr_pkg::t_res     o_quot
);
    import wtcr_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MULA = 2'd1;
    localparam logic [1:0] P_MULB = 2'd2;
    localparam logic [1:0] P_DIV  = 2'd3;

    localparam logic [4:0] MULA_LAST = 5'(RES_W - 1);
    localparam logic [4:0] MULB_LAST = 5'(MAG_W - 1);
    localparam logic [4:0] DIV_LAST  = 5'(RES_W - 1);

    logic [1:0]       r_phase, n_phase;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [NUM_W-1:0] r_mc, n_mc;       // multiplicand, later the shifted divisor
    logic [RES_W-1:0] r_mp, n_mp;       // multiplier bits, LSB first
    logic [NUM_W-1:0] r_acc, n_acc;     // product, later the remainder
    logic [DEN_W-2:0] r_dc1, n_dc1;
    logic [DEN_W-2:0] r_dc2, n_dc2;
    logic [MAG_W-1:0] r_dp1, n_dp1;
    logic [MAG_W-1:0] r_dp2, n_dp2;
    logic [DEN_W-1:0] r_den, n_den;
    logic [MAG_W-1:0] r_m, n_m;
    t_res             r_quot, n_quot;

    logic [NUM_W-1:0] mul_sum;
    logic [DEN_W-1:0] den_sum;
    logic [NUM_W-1:0] div_diff;
    logic             div_ge;

    always_comb begin
        mul_sum  = r_acc + (r_mp[0] ? r_mc : '0);
        den_sum  = r_den + (r_dp1[0] ? {1'b0, r_dc1} : '0)
                         + (r_dp2[0] ? {1'b0, r_dc2} : '0);
        div_ge   = (r_acc >= r_mc);
        div_diff = r_acc - r_mc;

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_mc    = r_mc;
        n_mp    = r_mp;
        n_acc   = r_acc;
        n_dc1   = r_dc1;
        n_dc2   = r_dc2;
        n_dp1   = r_dp1;
        n_dp2   = r_dp2;
        n_den   = r_den;
        n_m     = r_m;
        n_quot  = r_quot;

        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_phase = P_MULA;
                    n_cnt   = '0;
                    n_mc    = NUM_W'(i_op.ron);
                    n_mp    = i_op.roff;
                    n_acc   = '0;
                    n_dc1   = (DEN_W-1)'(i_op.ron);
                    n_dc2   = (DEN_W-1)'(i_op.roff - i_op.ron);
                    n_dp1   = i_op.m;
                    n_dp2   = i_op.mag;
                    n_den   = '0;
                    n_m     = i_op.m;
                end
            end
            P_MULA: begin
                // on * off, with the denominator built alongside
                n_acc = mul_sum;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_den = den_sum;
                n_dc1 = r_dc1 << 1;
                n_dc2 = r_dc2 << 1;
                n_dp1 = r_dp1 >> 1;
                n_dp2 = r_dp2 >> 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == MULA_LAST) begin
                    n_phase = P_MULB;
                    n_cnt   = '0;
                    n_mc    = mul_sum;
                    n_mp    = RES_W'(r_m);
                    n_acc   = '0;
                end
            end
            P_MULB: begin
                n_acc = mul_sum;
                n_mc  = r_mc << 1;
                n_mp  = r_mp >> 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == MULB_LAST) begin
                    n_phase = P_DIV;
                    n_cnt   = '0;
                    n_mc    = {r_den, (NUM_W-DEN_W)'(0)};
                    n_quot  = '0;
                end
            end
            P_DIV: begin
                // restoring division, one quotient bit per cycle, MSB first
                if (div_ge) begin
                    n_acc = div_diff;
                end
                n_quot = {r_quot[RES_W-2:0], div_ge};
                n_mc   = r_mc >> 1;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_acc  <= n_acc;
        r_dc1  <= n_dc1;
        r_dc2  <= n_dc2;
        r_dp1  <= n_dp1;
        r_dp2  <= n_dp2;
        r_den  <= n_den;
        r_m    <= n_m;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: src/weight_to_crossbar_resistance_top.sv
// Differential-pair resistance mapper for a crossbar readout layer.
// Channels: i_cfg writes on/off resistance and the row and output counts (always
// ready); i_in carries one request (clear largest magnitude, write weight, read
// resistance); o_out returns exactly one result per request.
// Clear, write, unused codes and reads that fail a check place their result in
// the output register in the cycle after the transfer.
// A good read of a nonzero weight on its own side: the weight memory is read
// at the transfer, the side is checked in the evaluate state, then a shared
// bit-serial unit works out on*off, the product with the largest magnitude
// and the quotient by restoring division, one quotient bit a cycle; completion
// is registered and the push state hands the result to the output register.
// One request is worked at a time; the next is taken once the block is idle
// and the output register is empty or being emptied.
// A stalled receiver holds the result in the output register; the block then
// takes no new request.
// Reset restores the register defaults and clears the largest magnitude; the
// weight store is not cleared and must be written before it is read.
module weight_to_crossbar_resistance_top #(
    parameter int MAX_NEURONS = 256,
    parameter int MAX_OUTPUTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtcr_cfg_if.sink    i_cfg,
    wtcr_in_if.sink     i_in,
    wtcr_out_if.source  o_out
);
    import wtcr_pkg::*;

    localparam int DEPTH  = MAX_NEURONS * MAX_OUTPUTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]        r_state;
    t_res              r_ron, r_roff;
    logic [NCNT_W-1:0] r_ncount;
    logic [OCNT_W-1:0] r_ocount;
    t_mag              r_mag;
    logic              r_out_valid;
    t_res              r_out_res;
    t_status           r_out_status;
    t_res              r_res;
    logic              r_side;
    t_weight           r_rd_data;

    t_weight           mem [DEPTH];

    logic              in_ready, in_acc, idx_ok, wr_en, rd_en, read_go;
    logic [ADDR_W-1:0] addr;
    t_weight           w_clamped;
    t_mag              w_abs;
    logic              rd_neg;
    t_mag              rd_abs;
    logic              calc_start, calc_done;
    t_res              calc_quot;
    t_calc_op          calc_op;
    logic              out_free;
    logic              out_load;
    t_status           acc_status;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign in_acc   = i_in.valid && in_ready;

    assign idx_ok = (32'(i_in.neuron) < MAX_NEURONS)
                 && ({1'b0, i_in.neuron} < r_ncount)
                 && (32'(i_in.output_req) < MAX_OUTPUTS)
                 && ({1'b0, i_in.output_req} < r_ocount);

    assign addr = ADDR_W'(i_in.output_req) * ADDR_W'(MAX_NEURONS) + ADDR_W'(i_in.neuron);

    // the most negative code has no positive twin: fold it one step in
    assign w_clamped = (i_in.weight == 16'sh8000) ? 16'sh8001 : i_in.weight;
    assign w_abs     = w_clamped[WGT_W-1] ? MAG_W'(-w_clamped) : w_clamped[MAG_W-1:0];

    assign read_go = (r_roff > r_ron) && idx_ok && (r_mag != '0);
    assign wr_en   = in_acc && (i_in.func == FN_WRITE) && idx_ok;
    assign rd_en   = in_acc && (i_in.func == FN_READ) && read_go;

    // load the output register on a direct answer or at the end of a read
    assign out_load = (in_acc && !rd_en) || ((r_state == S_PUSH) && out_free);

    always_comb begin
        case (i_in.func)
            FN_WRITE: acc_status = idx_ok ? ST_OK : ST_INDEX;
            FN_READ: begin
                if (!(r_roff > r_ron)) begin
                    acc_status = ST_RANGE_BAD;
                end else if (!idx_ok) begin
                    acc_status = ST_INDEX;
                end else begin
                    acc_status = ST_ZERO;
                end
            end
            default: acc_status = ST_OK;
        endcase
    end

    assign rd_neg     = r_rd_data[WGT_W-1];
    assign rd_abs     = rd_neg ? MAG_W'(-r_rd_data) : r_rd_data[MAG_W-1:0];
    assign calc_start = (r_state == S_EVAL) && (r_rd_data != '0) && (r_side == rd_neg);

    assign calc_op.ron  = r_ron;
    assign calc_op.roff = r_roff;
    assign calc_op.m    = r_mag;
    assign calc_op.mag  = rd_abs;

    wtcr_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (calc_start),
        .i_op    (calc_op),
        .o_done  (calc_done),
        .o_quot  (calc_quot)
    );

    // weight store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[addr] <= w_clamped;
        end
        if (rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ron    <= RON_RESET;
            r_roff   <= ROFF_RESET;
            r_ncount <= NCNT_RESET;
            r_ocount <= OCNT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ON_RES:  r_ron    <= i_cfg.data;
                CFG_OFF_RES: r_roff   <= i_cfg.data;
                CFG_NEURONS: r_ncount <= i_cfg.data[NCNT_W-1:0];
                CFG_OUTPUTS: r_ocount <= i_cfg.data[OCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.func == FN_CLEAR) begin
                            r_mag <= '0;
                        end else if (wr_en && (w_abs > r_mag)) begin
                            r_mag <= w_abs;
                        end
                        if (rd_en) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: r_state <= calc_start ? S_CALC : S_PUSH;
                S_CALC: begin
                    if (calc_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_side       <= i_in.side;
            r_out_res    <= '0;
            r_out_status <= acc_status;
        end
        if (r_state == S_EVAL) begin
            r_res <= r_roff;
        end else if ((r_state == S_CALC) && calc_done) begin
            r_res <= calc_quot;
        end
        if ((r_state == S_PUSH) && out_free) begin
            r_out_res    <= r_res;
            r_out_status <= ST_OK;
        end
    end

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.resistance = r_out_res;
    assign o_out.status     = r_out_status;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !in_ready)
        else $error("request taken while a read is in progress");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        calc_done |-> (r_state == S_CALC))
        else $error("calculation finished outside the calculation state");

    a_read_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_state == S_EVAL))
        else $error("store read not followed by side selection");

    a_mag_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(in_acc && (i_in.func == FN_CLEAR))) |=> (r_mag >= $past(r_mag)))
        else $error("largest magnitude dropped without a clear");

endmodule

FILE: test/wtcr_result_checker.sv
module wtcr_result_checker #(
    parameter int MAX_NEURONS = 256,
    parameter int MAX_OUTPUTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wtcr_cfg_if  cfg_ch,
    wtcr_in_if   req_ch,
    wtcr_out_if  res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import wtcr_pkg::*;

    localparam int STORE_DEPTH = MAX_NEURONS * MAX_OUTPUTS;

    typedef struct packed {
        t_res    resistance;
        t_status status;
    } t_reading;

    t_weight            weight_copy [STORE_DEPTH];
    t_mag               peak_mag;
    t_res               ron;
    t_res               roff;
    logic [NCNT_W-1:0]  row_count;
    logic [OCNT_W-1:0]  col_count;
    t_reading           expected_readings [$];

    function automatic bit in_range(input logic [7:0] n, input logic [3:0] o);
        int row_lim;
        int col_lim;
        row_lim = (int'(row_count) < MAX_NEURONS) ? int'(row_count) : MAX_NEURONS;
        col_lim = (int'(col_count) < MAX_OUTPUTS) ? int'(col_count) : MAX_OUTPUTS;
        return (int'(n) < row_lim) && (int'(o) < col_lim);
    endfunction

    // Update the copied state for one request and return the reading it produces.
    function automatic t_reading map_request(input t_func f, input logic [7:0] n,
                                             input logic [3:0] o, input logic side,
                                             input t_weight w_in);
        t_reading    r;
        t_weight     w;
        t_mag        mag;
        int          addr;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        r.resistance = '0;
        r.status     = ST_OK;
        addr = (int'(o) * MAX_NEURONS + int'(n)) % STORE_DEPTH;
        case (f)
            FN_CLEAR: begin
                peak_mag = '0;
            end
            FN_WRITE: begin
                if (!in_range(n, o)) begin
                    r.status = ST_INDEX;
                end else begin
                    // the most negative code has no positive twin: clamp it
                    w = (w_in == 16'sh8000) ? -16'sd32767 : w_in;
                    mag = t_mag'((w < 0) ? -w : w);
                    weight_copy[addr] = w;
                    if (mag > peak_mag)
                        peak_mag = mag;
                end
            end
            FN_READ: begin
                if (roff <= ron) begin
                    r.status = ST_RANGE_BAD;
                end else if (!in_range(n, o)) begin
                    r.status = ST_INDEX;
                end else if (peak_mag == '0) begin
                    r.status = ST_ZERO;
                end else begin
                    w = weight_copy[addr];
                    mag = t_mag'((w < 0) ? -w : w);
                    if (w == 0 || side != (w < 0)) begin
                        r.resistance = roff;
                    end else begin
                        num = 64'(ron) * 64'(roff) * 64'(peak_mag);
                        den = 64'(ron) * 64'(peak_mag) + 64'(roff - ron) * 64'(mag);
                        quo = (den != 0) ? num / den : 64'(roff);
                        r.resistance = quo[RES_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            peak_mag     = '0;
            ron          = RON_RESET;
            roff         = ROFF_RESET;
            row_count    = NCNT_RESET;
            col_count    = OCNT_RESET;
            o_fail_count = 0;
            expected_readings.delete();
        end else begin
            // retire the result first: a request taken at this edge cannot answer yet
            if (res_ch.valid && res_ch.ready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result: resistance %0d, status %0d",
                           res_ch.resistance, res_ch.status);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (res_ch.resistance !== want.resistance) begin
                        $error("resistance: expected %0d, got %0d",
                               want.resistance, res_ch.resistance);
                        o_fail_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        o_fail_count++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_ON_RES:  ron = cfg_ch.data;
                    CFG_OFF_RES: roff = cfg_ch.data;
                    CFG_NEURONS: row_count = cfg_ch.data[NCNT_W-1:0];
                    CFG_OUTPUTS: col_count = cfg_ch.data[OCNT_W-1:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                expected_readings.push_back(map_request(req_ch.func, req_ch.neuron,
                                                        req_ch.output_req, req_ch.side,
                                                        req_ch.weight));
        end
        o_pending = expected_readings.size();
    end

endmodule

FILE: test/tb_weight_to_crossbar_resistance_top.sv
module tb_weight_to_crossbar_resistance_top;
    import wtcr_pkg::*;

    localparam int MAX_NEURONS  = 256;
    localparam int MAX_OUTPUTS  = 16;
    localparam int STORE_DEPTH  = MAX_NEURONS * MAX_OUTPUTS;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES       = 9;

    localparam t_func FN_UNUSED = 2'd3;

    typedef struct {
        t_func      func;
        logic [7:0] neuron;
        logic [3:0] output_req;
        logic       side;
        t_weight    weight;
    } t_request;

    typedef struct {
        t_res ron;
        t_res roff;
        t_res rows;
        t_res cols;
        int   count;
    } t_phase;

    logic i_clk;
    logic i_rst_n;

    wtcr_cfg_if cfg_ch ();
    wtcr_in_if  req_ch ();
    wtcr_out_if res_ch ();

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int sent_count;
    int row_lim;
    int col_lim;
    bit written [STORE_DEPTH];
    int written_addr [$];

    weight_to_crossbar_resistance_top #(
        .MAX_NEURONS(MAX_NEURONS),
        .MAX_OUTPUTS(MAX_OUTPUTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (req_ch),
        .o_out  (res_ch)
    );

    wtcr_result_checker #(
        .MAX_NEURONS(MAX_NEURONS),
        .MAX_OUTPUTS(MAX_OUTPUTS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cfg_ch      (cfg_ch),
        .req_ch      (req_ch),
        .res_ch      (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        #6000000;
        $display("weight_to_crossbar_resistance_top test failed");
        $finish;
    end

    function automatic bit addr_in_range(input int n, input int o);
        return (n < row_lim) && (o < col_lim);
    endfunction

    function automatic t_request make_req(input t_func f, input int n, input int o,
                                          input bit s, input int w);
        t_request r;
        r.func       = f;
        r.neuron     = n[7:0];
        r.output_req = o[3:0];
        r.side       = s;
        r.weight     = t_weight'(w);
        return r;
    endfunction

    function automatic t_weight random_weight();
        t_weight w;
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(5))
                    0:       w = 16'sd32767;
                    1:       w = -16'sd32767;
                    2:       w = 16'sh8000;
                    3:       w = 16'sd0;
                    4:       w = 16'sd1;
                    default: w = -16'sd1;
                endcase
            end
            1, 2:    w = t_weight'(int'($urandom_range(512)) - 256);
            default: w = t_weight'($urandom);
        endcase
        return w;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       addr;
        pick         = $urandom_range(99);
        r.func       = FN_READ;
        r.neuron     = 8'($urandom);
        r.output_req = 4'($urandom);
        r.side       = 1'($urandom);
        r.weight     = random_weight();
        if (pick < 35) begin
            r.func = FN_WRITE;
            if (written_addr.size() > 0 && $urandom_range(99) < 30) begin
                addr         = written_addr[$urandom_range(written_addr.size() - 1)];
                r.neuron     = 8'(addr % MAX_NEURONS);
                r.output_req = 4'(addr / MAX_NEURONS);
            end else if ($urandom_range(99) < 80) begin
                r.neuron     = 8'($urandom_range(row_lim - 1));
                r.output_req = 4'($urandom_range(col_lim - 1));
            end
        end else if (pick < 82) begin
            // read back something already written most of the time
            if (written_addr.size() > 0 && $urandom_range(99) < 80) begin
                addr         = written_addr[$urandom_range(written_addr.size() - 1)];
                r.neuron     = 8'(addr % MAX_NEURONS);
                r.output_req = 4'(addr / MAX_NEURONS);
            end
        end else if (pick < 88) begin
            r.func = FN_CLEAR;
        end else if (pick < 93) begin
            r.func = FN_UNUSED;
        end
        return r;
    endfunction

    task automatic issue(input t_request r);
        int addr;
        if (sent_count < 240) begin
            send_idle = 24;
            recv_idle = 58;
        end else if (sent_count < 480) begin
            send_idle = 58;
            recv_idle = 24;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        addr = int'(r.output_req) * MAX_NEURONS + int'(r.neuron);
        // never read a store entry that has not been written: write it instead
        if (r.func == FN_READ && addr_in_range(int'(r.neuron), int'(r.output_req))
            && !written[addr])
            r.func = FN_WRITE;
        if (r.func == FN_WRITE && addr_in_range(int'(r.neuron), int'(r.output_req))
            && !written[addr]) begin
            written[addr] = 1'b1;
            written_addr.push_back(addr);
        end
        @(negedge i_clk);
        if (send_idle > 0 && $urandom_range(99) < 4) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(80, 1)) @(negedge i_clk);
        end
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= r.func;
        req_ch.neuron     <= r.neuron;
        req_ch.output_req <= r.output_req;
        req_ch.side       <= r.side;
        req_ch.weight     <= r.weight;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_res data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // Drain the block, then load one set of registers.
    task automatic apply_settings(input t_phase p);
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_ON_RES, p.ron);
        write_reg(CFG_OFF_RES, p.roff);
        write_reg(CFG_NEURONS, p.rows);
        write_reg(CFG_OUTPUTS, p.cols);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        row_lim = (int'(p.rows[NCNT_W-1:0]) < MAX_NEURONS) ? int'(p.rows[NCNT_W-1:0])
                                                            : MAX_NEURONS;
        col_lim = (int'(p.cols[OCNT_W-1:0]) < MAX_OUTPUTS) ? int'(p.cols[OCNT_W-1:0])
                                                            : MAX_OUTPUTS;
    endtask

    initial begin
        t_phase plan [PHASES];
        t_res   lo;
        i_rst_n           = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_ON_RES;
        cfg_ch.data       = '0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FN_CLEAR;
        req_ch.neuron     = '0;
        req_ch.output_req = '0;
        req_ch.side       = 1'b0;
        req_ch.weight     = '0;
        send_idle         = 0;
        recv_idle         = 0;
        sent_count        = 0;
        row_lim           = MAX_NEURONS;
        col_lim           = MAX_OUTPUTS;

        plan[0] = '{RON_RESET, ROFF_RESET, 24'(NCNT_RESET), 24'(OCNT_RESET), 80};
        plan[1] = '{24'd1, 24'hFFFFFF, 24'd256, 24'd16, 90};
        plan[2] = '{24'hFFFFFF, 24'hFFFFFF, 24'd5, 24'd2, 60};
        lo = t_res'($urandom_range(1000, 1));
        plan[3] = '{lo, t_res'($urandom_range(24'hFFFFFF, lo + 1)), 24'd1, 24'd1, 70};
        // zero on resistance, and counts above the array size with junk in the upper bits
        plan[4] = '{24'd0, t_res'($urandom_range(24'hFFFFFF, 1)),
                    {15'($urandom), 9'd300}, {19'($urandom), 5'd20}, 70};
        plan[5] = '{24'hFFFFFE, 24'hFFFFFF, 24'd256, 24'd16, 90};
        plan[6] = '{24'hFFFFFF, 24'd1, 24'd256, 24'd16, 40};
        lo = t_res'($urandom_range(24'h7FFFFF, 1));
        plan[7] = '{lo, t_res'($urandom_range(24'hFFFFFF, lo + 1)),
                    t_res'($urandom_range(256, 1)), t_res'($urandom_range(16, 1)), 120};
        plan[8] = '{24'd1000, 24'd1000000, 24'd256, 24'd16, 80};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening under reset settings
        issue(make_req(FN_CLEAR, 0, 0, 0, 0));
        issue(make_req(FN_WRITE, 0, 0, 0, 0));
        issue(make_req(FN_READ, 0, 0, 0, 0));
        issue(make_req(FN_WRITE, 255, 15, 0, 32767));
        issue(make_req(FN_WRITE, 1, 0, 0, -32768));
        issue(make_req(FN_WRITE, 2, 0, 0, 1));
        issue(make_req(FN_WRITE, 3, 0, 0, -1));
        issue(make_req(FN_READ, 255, 15, 0, 0));
        issue(make_req(FN_READ, 255, 15, 1, 0));
        issue(make_req(FN_READ, 1, 0, 1, 0));
        issue(make_req(FN_READ, 1, 0, 0, 0));
        issue(make_req(FN_READ, 2, 0, 0, 0));
        issue(make_req(FN_READ, 3, 0, 1, 0));
        issue(make_req(FN_READ, 0, 0, 0, 0));
        issue(make_req(FN_READ, 0, 0, 1, 0));
        issue(make_req(FN_UNUSED, 170, 10, 1, -21846));
        issue(make_req(FN_CLEAR, 0, 0, 0, 0));
        issue(make_req(FN_READ, 2, 0, 0, 0));
        // largest magnitude now below the stored weight
        issue(make_req(FN_WRITE, 4, 0, 0, 100));
        issue(make_req(FN_READ, 255, 15, 0, 0));
        issue(make_req(FN_WRITE, 170, 10, 0, 21845));
        issue(make_req(FN_READ, 170, 10, 0, 0));
        issue(make_req(FN_WRITE, 85, 5, 0, -21846));
        issue(make_req(FN_READ, 85, 5, 1, 0));

        for (int k = 0; k < PHASES; k++) begin
            if (k > 0)
                apply_settings(plan[k]);
            repeat (plan[k].count) issue(random_request());
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("weight_to_crossbar_resistance_top test passed");
        end else begin
            $display("weight_to_crossbar_resistance_top test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/wtcr_pkg.sv
src/wtcr_ifs.sv
src/wtcr_calc.sv
src/weight_to_crossbar_resistance_top.sv
test/wtcr_result_checker.sv
test/tb_weight_to_crossbar_resistance_top.sv
